// File: hw/rtl/adc2w_pkg.sv
// Shared types and constants for the two-wire delta-sigma ADC readout controller.
// Used by the front end, the queue, the engine, the checker and the top level.
`default_nettype none

package adc2w_pkg;

  localparam int unsigned DATA_BITS_DEFAULT   = 24;
  localparam int unsigned TRAILER_CLOCKS      = 3;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  localparam int unsigned CFG_WIDTH   = 32;
  localparam int unsigned CFG_INDEX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_PERIOD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_READY_TIMEOUT = 1'b1;

  localparam logic [31:0] READY_TIMEOUT_RESET = 32'd400000;

  // Function codes on the input channel.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Converter command bytes, seven bits wide on the wire.
  localparam logic [6:0] CMD_WR = 7'h65;
  localparam logic [6:0] CMD_RD = 7'h56;

  localparam logic [31:0] ERR_WORD     = 32'h4000_0000;
  localparam logic [7:0]  TIMEOUT_BYTE = 8'hFF;

  // Configuration frame layout, in serial clocks; FRAME_LAST counts half clocks.
  localparam logic [5:0] FRM_DRIVE_HIGH = 6'd27;
  localparam logic [5:0] FRM_CMD_FIRST  = 6'd29;
  localparam logic [5:0] FRM_CMD_GAP    = 6'd36;
  localparam logic [5:0] FRM_DATA_LAST  = 6'd44;
  localparam logic [5:0] FRM_RELEASE    = 6'd45;
  localparam logic [6:0] FRAME_LAST     = 7'd91;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  typedef struct packed {
    req_t       kind;
    logic [7:0] write_value;
    logic       dout_level;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [5:0] {
    MODE_IDLE     = 6'b000001,
    MODE_SAMPLE   = 6'b000010,
    MODE_WAIT_WR  = 6'b000100,
    MODE_WAIT_RD  = 6'b001000,
    MODE_FRAME_WR = 6'b010000,
    MODE_FRAME_RD = 6'b100000
  } mode_t;

  typedef struct packed {
    logic              sclk_level;
    logic              din_level;
    logic              din_drive;
    logic              sample_valid;
    logic signed [31:0] sample_value;
    logic              sample_error;
    logic              config_valid;
    logic [7:0]        config_value;
    logic              busy_res;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/adc2w_if.sv
// Valid/ready channel interfaces for tick items and result items.
// Depends on nothing but plain logic types.
`default_nettype none

interface adc2w_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] write_value;
  logic       dout_level;

  modport source (output valid, func, write_value, dout_level, input ready);
  modport sink (input valid, func, write_value, dout_level, output ready);
  modport monitor (input valid, ready, func, write_value, dout_level);
endinterface

interface adc2w_out_if;
  logic               valid;
  logic               ready;
  logic               sclk_level;
  logic               din_level;
  logic               din_drive;
  logic               sample_valid;
  logic signed [31:0] sample_value;
  logic               sample_error;
  logic               config_valid;
  logic [7:0]         config_value;
  logic               busy_res;

  modport source (output valid, sclk_level, din_level, din_drive, sample_valid, sample_value,
                  sample_error, config_valid, config_value, busy_res, input ready);
  modport sink (input valid, sclk_level, din_level, din_drive, sample_valid, sample_value,
                sample_error, config_valid, config_value, busy_res, output ready);
  modport monitor (input valid, ready, sclk_level, din_level, din_drive, sample_valid,
                   sample_value, sample_error, config_valid, config_value, busy_res);
endinterface

`default_nettype wire

// File: hw/rtl/adc2w_front.sv
// Front end: accepts tick transactions and classifies the function code.
// Depends on adc2w_pkg and adc2w_in_if.
`default_nettype none

module adc2w_front (
  adc2w_in_if.sink                   in_ch,
  input  adc2w_pkg::queue_status_t   q_status,
  output logic                       push,
  output adc2w_pkg::item_t           push_item
);

  assign in_ch.ready = !q_status.full;
  assign push        = in_ch.valid && !q_status.full;

  // Function code three carries no request and runs as a plain tick.
  always_comb begin
    case (in_ch.func)
      adc2w_pkg::FUNC_WRITE: push_item.kind = adc2w_pkg::REQ_WRITE;
      adc2w_pkg::FUNC_READ:  push_item.kind = adc2w_pkg::REQ_READ;
      default:               push_item.kind = adc2w_pkg::REQ_TICK;
    endcase
    push_item.write_value = in_ch.write_value;
    push_item.dout_level  = in_ch.dout_level;
  end

endmodule

`default_nettype wire

// File: hw/rtl/adc2w_queue.sv
// Short FIFO of classified tick items between the front end and the engine.
// Depends on adc2w_pkg.
`default_nettype none

module adc2w_queue #(
  parameter int unsigned DEPTH = adc2w_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  adc2w_pkg::item_t         push_item,
  input  logic                     pop,
  output adc2w_pkg::item_t         head,
  output adc2w_pkg::queue_status_t status
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  adc2w_pkg::item_t entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/adc2w_engine.sv
// Back end: runs the sample reads, config frames and period timer one tick per cycle while the queue holds a tick
// and the output is not stalled, and holds the result in an output register. Depends on adc2w_pkg and adc2w_out_if.
`default_nettype none

module adc2w_engine #(
  parameter int unsigned DATA_BITS = adc2w_pkg::DATA_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  adc2w_pkg::item_t                      head,
  input  adc2w_pkg::queue_status_t              q_status,
  output logic                                  pop,
  input  logic                                  cfg_we,
  input  logic [adc2w_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [adc2w_pkg::CFG_WIDTH-1:0]       cfg_data,
  adc2w_out_if.source                           out_ch
);

  localparam logic [6:0] SAMPLE_LAST =
    7'(2 * (DATA_BITS + adc2w_pkg::TRAILER_CLOCKS) - 1);
  localparam logic [5:0] DATA_CLOCKS = 6'(DATA_BITS);

  adc2w_pkg::mode_t mode, mode_mid, mode_next;
  logic [6:0]           clock_step, clock_step_mid, clock_step_next;
  logic [DATA_BITS-1:0] shift_data, shift_data_mid, shift_data_next, shifted;
  logic [7:0]           command_shift, command_shift_next;
  logic [31:0]          period_counter, period_counter_next;
  logic [31:0]          wait_counter, wait_counter_mid, wait_counter_next, wait_inc;
  logic [31:0]          sample_period, ready_timeout, timeout_lim;
  logic [31:0]          reload_x4, reload_x8, sample_ext;
  logic                 pending_flag, pending_flag_next;
  logic                 overrun_flag, overrun_flag_next;
  logic                 error_latch, error_latch_next;
  logic [5:0]           clk_idx;
  logic [6:0]           cmd;
  logic                 frame_wr;
  logic                 out_valid;
  adc2w_pkg::result_t   res, out_res;

  assign pop = !q_status.empty && (!out_valid || out_ch.ready);

  assign clk_idx     = clock_step_mid[6:1];
  assign timeout_lim = (ready_timeout == '0) ? 32'd1 : ready_timeout;
  assign reload_x4   = (|sample_period[31:30]) ? '1 : {sample_period[29:0], 2'b00};
  assign reload_x8   = (|sample_period[31:29]) ? '1 : {sample_period[28:0], 3'b000};
  assign frame_wr    = (mode_mid == adc2w_pkg::MODE_FRAME_WR);
  assign cmd         = frame_wr ? adc2w_pkg::CMD_WR : adc2w_pkg::CMD_RD;
  assign shifted     = {shift_data_mid[DATA_BITS-2:0], head.dout_level};
  assign wait_inc    = (wait_counter_mid == '1) ? wait_counter_mid : wait_counter_mid + 32'd1;

  // Requests are taken only when idle and go ahead of a pending sample read.
  always_comb begin
    mode_mid           = mode;
    clock_step_mid     = clock_step;
    shift_data_mid     = shift_data;
    wait_counter_mid   = wait_counter;
    command_shift_next = command_shift;
    if (mode == adc2w_pkg::MODE_IDLE) begin
      if (head.kind == adc2w_pkg::REQ_WRITE || head.kind == adc2w_pkg::REQ_READ) begin
        mode_mid           = (head.kind == adc2w_pkg::REQ_WRITE) ?
                             adc2w_pkg::MODE_WAIT_WR : adc2w_pkg::MODE_WAIT_RD;
        wait_counter_mid   = '0;
        command_shift_next = head.write_value;
      end else if (pending_flag) begin
        mode_mid       = adc2w_pkg::MODE_SAMPLE;
        clock_step_mid = '0;
        shift_data_mid = '0;
      end
    end
  end

  always_comb begin
    mode_next           = mode_mid;
    clock_step_next     = clock_step_mid + 7'd1;
    shift_data_next     = shift_data_mid;
    wait_counter_next   = wait_counter_mid;
    pending_flag_next   = pending_flag;
    overrun_flag_next   = overrun_flag;
    error_latch_next    = error_latch;
    period_counter_next = period_counter;
    sample_ext          = '0;
    res                 = '0;

    case (mode_mid)
      adc2w_pkg::MODE_WAIT_WR, adc2w_pkg::MODE_WAIT_RD: begin
        if (!head.dout_level) begin
          // The frame starts on the next tick from its first half clock.
          mode_next       = (mode_mid == adc2w_pkg::MODE_WAIT_WR) ?
                            adc2w_pkg::MODE_FRAME_WR : adc2w_pkg::MODE_FRAME_RD;
          clock_step_next = '0;
          shift_data_next = '0;
        end else begin
          wait_counter_next = wait_inc;
          if (wait_inc >= timeout_lim) begin
            res.config_valid = 1'b1;
            res.config_value = adc2w_pkg::TIMEOUT_BYTE;
            mode_next        = adc2w_pkg::MODE_IDLE;
          end
        end
      end
      adc2w_pkg::MODE_SAMPLE: begin
        if (!clock_step_mid[0]) begin
          res.sclk_level = 1'b1;
        end else begin
          if (clk_idx < DATA_CLOCKS) begin
            shift_data_next = shifted;
          end
          if (clock_step_mid >= SAMPLE_LAST) begin
            sample_ext        = {{(32 - DATA_BITS){shift_data_next[DATA_BITS-1]}},
                                 shift_data_next};
            pending_flag_next = 1'b0;
            overrun_flag_next = 1'b0;
            error_latch_next  = error_latch || overrun_flag;
            res.sample_valid  = 1'b1;
            res.sample_error  = error_latch_next;
            res.sample_value  = error_latch_next ? adc2w_pkg::ERR_WORD : sample_ext;
            mode_next         = adc2w_pkg::MODE_IDLE;
          end
        end
      end
      adc2w_pkg::MODE_FRAME_WR, adc2w_pkg::MODE_FRAME_RD: begin
        res.sclk_level = !clock_step_mid[0];
        if (clk_idx < adc2w_pkg::FRM_DRIVE_HIGH) begin
          res.din_drive = 1'b0;
        end else if (clk_idx < adc2w_pkg::FRM_CMD_FIRST) begin
          res.din_drive = 1'b1;
          res.din_level = 1'b1;
        end else if (clk_idx < adc2w_pkg::FRM_CMD_GAP) begin
          res.din_drive = 1'b1;
          res.din_level = cmd[3'(adc2w_pkg::FRM_CMD_GAP - 6'd1 - clk_idx)];
        end else if (clk_idx == adc2w_pkg::FRM_CMD_GAP) begin
          // A write keeps driving the last command bit; a read turns the pin around.
          res.din_drive = frame_wr;
          res.din_level = frame_wr && cmd[0];
        end else if (clk_idx < adc2w_pkg::FRM_RELEASE) begin
          if (frame_wr) begin
            res.din_drive = 1'b1;
            res.din_level = command_shift_next[3'(adc2w_pkg::FRM_DATA_LAST - clk_idx)];
          end else if (clock_step_mid[0]) begin
            shift_data_next = shifted;
          end
        end
        if (clock_step_mid >= adc2w_pkg::FRAME_LAST) begin
          res.config_valid = 1'b1;
          res.config_value = frame_wr ? 8'h00 : shift_data_next[7:0];
          mode_next        = adc2w_pkg::MODE_IDLE;
        end
      end
      default: begin
        mode_next = adc2w_pkg::MODE_IDLE;
      end
    endcase

    if (sample_period != '0) begin
      if (period_counter <= 32'd1) begin
        if (pending_flag_next) begin
          overrun_flag_next   = 1'b1;
          period_counter_next = reload_x4;
        end else if (!head.dout_level) begin
          pending_flag_next   = 1'b1;
          period_counter_next = reload_x8;
        end else begin
          period_counter_next = sample_period;
        end
      end else begin
        period_counter_next = period_counter - 32'd1;
      end
    end

    res.busy_res = (mode_next != adc2w_pkg::MODE_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= adc2w_pkg::MODE_IDLE;
      clock_step     <= '0;
      shift_data     <= '0;
      command_shift  <= '0;
      period_counter <= '0;
      wait_counter   <= '0;
      pending_flag   <= 1'b0;
      overrun_flag   <= 1'b0;
      error_latch    <= 1'b0;
      sample_period  <= '0;
      ready_timeout  <= adc2w_pkg::READY_TIMEOUT_RESET;
      out_valid      <= 1'b0;
    end else begin
      if (pop) begin
        mode           <= mode_next;
        clock_step     <= clock_step_next;
        shift_data     <= shift_data_next;
        command_shift  <= command_shift_next;
        period_counter <= period_counter_next;
        wait_counter   <= wait_counter_next;
        pending_flag   <= pending_flag_next;
        overrun_flag   <= overrun_flag_next;
        error_latch    <= error_latch_next;
        out_valid      <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we && cfg_index == adc2w_pkg::CFG_SAMPLE_PERIOD) begin
        sample_period  <= cfg_data;
        period_counter <= cfg_data;
        pending_flag   <= 1'b0;
        overrun_flag   <= 1'b0;
        error_latch    <= 1'b0;
      end
      if (cfg_we && cfg_index == adc2w_pkg::CFG_READY_TIMEOUT) begin
        ready_timeout <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.sclk_level   = out_res.sclk_level;
  assign out_ch.din_level    = out_res.din_level;
  assign out_ch.din_drive    = out_res.din_drive;
  assign out_ch.sample_valid = out_res.sample_valid;
  assign out_ch.sample_value = out_res.sample_value;
  assign out_ch.sample_error = out_res.sample_error;
  assign out_ch.config_valid = out_res.config_valid;
  assign out_ch.config_value = out_res.config_value;
  assign out_ch.busy_res     = out_res.busy_res;

endmodule

`default_nettype wire

// File: hw/rtl/adc_two_wire_readout_controller.sv
// Top level of the two-wire delta-sigma ADC readout controller.
// Depends on adc2w_pkg, adc2w_if, adc2w_front, adc2w_queue and adc2w_engine.
//
//   Channel   Direction  Handshake     Carries
//   in_ch     sink       valid/ready   func, write_value, dout_level (one tick)
//   out_ch    source     valid/ready   pin levels, sample and config results
//   cfg       write      cfg_we        cfg_index, cfg_data (no wait, no read-back)
//
// One tick is taken per clock cycle while the queue has room; its result passes through the
// item queue and then the engine's output register before it is presented.
// Synchronous active-high reset; no clearing pass, the block is ready right away.
// A stalled output holds the engine, the queue then fills and in_ch.ready drops.
`default_nettype none

module adc_two_wire_readout_controller #(
  parameter int unsigned DATA_BITS   = adc2w_pkg::DATA_BITS_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = adc2w_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  adc2w_in_if.sink                          in_ch,
  adc2w_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [adc2w_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [adc2w_pkg::CFG_WIDTH-1:0]   cfg_data
);

  adc2w_pkg::item_t         push_item;
  adc2w_pkg::item_t         head;
  adc2w_pkg::queue_status_t q_status;
  logic                     push;
  logic                     pop;

  adc2w_front u_front (
    .in_ch     (in_ch),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  adc2w_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  adc2w_engine #(
    .DATA_BITS (DATA_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// File: hw/rtl/adc2w_checker.sv
// Port-level checks on the result channel of the readout controller, with its bind.
// Depends on adc2w_pkg and adc2w_out_if.
`default_nettype none

module adc2w_checker (
  input logic         clk,
  input logic         rst,
  adc2w_out_if.source out_ch
);

  // A stalled result stays valid and keeps its sample, config and busy fields.
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.sample_value)
      && $stable(out_ch.config_value) && $stable(out_ch.busy_res))
    else $error("result changed while stalled");

  // A finished sample or config frame always leaves the controller idle.
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.sample_valid || out_ch.config_valid) |-> !out_ch.busy_res)
    else $error("busy after a finished frame");

  // Sample reads and config frames never finish on the same tick.
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.sample_valid && out_ch.config_valid))
    else $error("sample and config finished together");

  // The error flag only comes with a sample and always carries the error word.
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.sample_error |->
      out_ch.sample_valid && out_ch.sample_value == adc2w_pkg::ERR_WORD)
    else $error("bad error word");

  // The data level is low whenever the pin is released.
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.din_drive |-> !out_ch.din_level)
    else $error("data level set on a released pin");

endmodule

bind adc_two_wire_readout_controller adc2w_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .out_ch (out_ch)
);

`default_nettype wire
